FILE: hw/rtl/sfv_pkg.sv
// Package: beat types, error codes and the CRC-8 byte update for the frame validator.
package sfv_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 64;
	localparam logic [7:0]  CRC_POLY_RESET  = 8'hD5;
	localparam logic [9:0]  MIN_BUFFER_BYTES = 10'd4;
	localparam logic [7:0]  MIN_LENGTH       = 8'd2;
	localparam logic [9:0]  MAX_FRAME_W      = 10'(MAX_FRAME_BYTES);
	localparam logic [8:0]  INDEX_MAX        = 9'd511;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_SHORT     = 3'd1,
		ERR_LEN_SMALL = 3'd2,
		ERR_TRUNCATED = 3'd3,
		ERR_TOO_LONG  = 3'd4,
		ERR_CRC       = 3'd5
	} err_code_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} sfv_in_t;

	typedef struct packed {
		logic       frame_ok;
		err_code_t  error_code;
		logic [7:0] kind_byte;
		logic [7:0] body_len;
	} sfv_out_t;

	function automatic logic [7:0] crc8_byte(
		input logic [7:0] crc,
		input logic [7:0] b,
		input logic [7:0] poly
	);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/serial_frame_validator_crc8_unit.sv
// Top level: frame validator with CRC-8 check, one byte beat per cycle.
// Throughput: one byte beat per cycle; a last byte beat waits while a verdict is held by result_stall.
// Order: the last byte beat is taken into the input register, then its verdict into the result register;
// while result_stall holds a verdict, the last byte beat waits in the input register.
// Reset: arst_n clears frame state, pipeline valids and sets crc_poly to 0xD5.
// Frame state clears itself after each verdict.
module serial_frame_validator_crc8_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  sfv_pkg::sfv_in_t  item,
	output logic              result_valid,
	input  logic              result_stall,
	output sfv_pkg::sfv_out_t result,
	input  logic              crc_poly_we,
	input  logic [7:0]        crc_poly_wdata
);
	import sfv_pkg::*;

	logic       valid_s1;
	sfv_in_t    item_s1;
	logic       fire_s1;
	logic       out_free;

	logic [7:0] crc_poly_q;
	logic [8:0] byte_index_q;
	logic [7:0] length_field_q;
	logic [7:0] type_field_q;
	logic [7:0] running_crc_q;
	logic       crc_matched_q;

	logic       result_valid_q;
	sfv_out_t   result_q;

	logic [7:0] len_eff;
	logic [7:0] type_eff;
	logic       crc_run;
	logic [7:0] crc_nxt;
	logic       cmp_here;
	logic       matched_eff;
	logic [9:0] n_bytes;
	logic [9:0] frame_bytes;
	err_code_t  code;
	sfv_out_t   verdict;

	assign out_free   = !result_valid_q || !result_stall;
	assign fire_s1    = valid_s1 && (!item_s1.last_byte || out_free);
	assign item_stall = valid_s1 && !fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q <= CRC_POLY_RESET;
		end else if (crc_poly_we) begin
			crc_poly_q <= crc_poly_wdata;
		end
	end

	always_comb begin
		len_eff     = (byte_index_q == 9'd1) ? item_s1.data_byte : length_field_q;
		type_eff    = (byte_index_q == 9'd2) ? item_s1.data_byte : type_field_q;
		crc_run     = (byte_index_q >= 9'd2) && (byte_index_q <= {1'b0, len_eff});
		crc_nxt     = crc_run ? crc8_byte(running_crc_q, item_s1.data_byte, crc_poly_q)
		                      : running_crc_q;
		cmp_here    = (byte_index_q == ({1'b0, len_eff} + 9'd1));
		matched_eff = cmp_here ? (running_crc_q == item_s1.data_byte) : crc_matched_q;
		n_bytes     = {1'b0, byte_index_q} + 10'd1;
		frame_bytes = {2'b00, len_eff} + 10'd2;

		if (n_bytes < MIN_BUFFER_BYTES) begin
			code = ERR_SHORT;
		end else if (len_eff < MIN_LENGTH) begin
			code = ERR_LEN_SMALL;
		end else if (frame_bytes > n_bytes) begin
			code = ERR_TRUNCATED;
		end else if (frame_bytes > MAX_FRAME_W) begin
			code = ERR_TOO_LONG;
		end else if (!matched_eff) begin
			code = ERR_CRC;
		end else begin
			code = ERR_OK;
		end

		verdict.frame_ok   = (code == ERR_OK);
		verdict.error_code = code;
		verdict.kind_byte  = (code == ERR_OK) ? type_eff : 8'd0;
		verdict.body_len   = (code == ERR_OK) ? (len_eff - MIN_LENGTH) : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q   <= '0;
			length_field_q <= '0;
			type_field_q   <= '0;
			running_crc_q  <= '0;
			crc_matched_q  <= 1'b0;
		end else if (fire_s1) begin
			if (item_s1.last_byte) begin
				byte_index_q   <= '0;
				length_field_q <= '0;
				type_field_q   <= '0;
				running_crc_q  <= '0;
				crc_matched_q  <= 1'b0;
			end else begin
				if (byte_index_q != INDEX_MAX) begin
					byte_index_q <= byte_index_q + 9'd1;
				end
				length_field_q <= len_eff;
				type_field_q   <= type_eff;
				running_crc_q  <= crc_nxt;
				crc_matched_q  <= matched_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s1 && item_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && item_s1.last_byte) begin
			result_q <= verdict;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: hw/rtl/sfv_chk.sv
// Checker: port-level properties of the frame validator, bound to the top level.
module sfv_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input sfv_pkg::sfv_in_t  item,
	input logic              result_valid,
	input logic              result_stall,
	input sfv_pkg::sfv_out_t result
);
	import sfv_pkg::*;

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled byte beat changed or dropped");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled verdict beat changed or dropped");

	a_ok_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.frame_ok == (result.error_code == ERR_OK)))
		else $error("frame_ok disagrees with error_code");

	a_fail_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.frame_ok |->
			(result.kind_byte == 8'd0) && (result.body_len == 8'd0))
		else $error("failed verdict carries type or length");

	a_ok_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_ok |->
			({2'b00, result.body_len} + 10'd4 <= MAX_FRAME_W))
		else $error("accepted frame exceeds maximum size");

endmodule

bind serial_frame_validator_crc8_unit sfv_chk u_sfv_chk (.*);
